@@ rtl/core/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, codes and controller/datapath interface types for the
// pedometer peak step detector.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int IDX_W      = $clog2(HIST_DEPTH);
  localparam int SPAN_LIM   = (16 < HIST_DEPTH) ? 16 : HIST_DEPTH;
  localparam int SPAN_W     = $clog2(SPAN_LIM + 1);
  localparam int CNT_W      = (IDX_W > 4) ? IDX_W : 4;

  localparam int AXIS_W     = 16;
  localparam int SQ_W       = 32;
  localparam int MAG_W      = 16;
  localparam int ROOT_STEPS = 16;
  localparam int SQ_STEPS   = 4;
  localparam int GAP_W      = 8;
  localparam int MODE_W     = 2;
  localparam int VIB_W      = 14;
  localparam int SPANCFG_W  = 10;
  localparam int FIELD_W    = 5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ONE_G      = 4096;
  localparam int PROM_MIN   = 409;

  localparam logic [MODE_W-1:0] MODE_SLOW   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FAST   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FAST_THR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_SLOW    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_NORMAL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIB_FAST    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_SLOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_NORMAL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_FAST   = 3'd7;

  typedef struct packed {
    logic             load;
    logic             sq_en;
    logic             acc_en;
    logic             root_step;
    logic             upd;
    logic             scan_en;
    logic             fin;
    logic [CNT_W-1:0] cnt;
  } pps_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } pps_sts_t;

endpackage

@@ rtl/core/pedometer_peak_step_detector_unit.sv @@
// ----------------------------------------------------------------------------
// pedometer_peak_step_detector_unit
// Accelerometer magnitude, gait classification and step peak detection.
// ----------------------------------------------------------------------------
//
//   channel  ports                                      direction
//   in       in_valid/in_ready, in_accel_x/y/z          sample in
//   out      out_valid/out_ready, out_step_found,       result out
//            out_magnitude, out_gait_mode
//   cfg      cfg_wr_en, cfg_index, cfg_wdata            register write
//
// each item goes from accept to out_valid through the shared squarer, the
// bit-serial root, the history update, the history scan over L entries, with
// L = max(range, window) of the selected gait (1..16), and the decision.
// a new item is taken in the cycle after the decision. synchronous active-low
// reset clears history, gap counter and out_valid, and loads config defaults.
// a result waiting on out_ready does not block the next accept; only the
// decision step holds until the output register is free.
module pedometer_peak_step_detector_unit
  import pps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [AXIS_W-1:0] in_accel_x,
  input  logic signed [AXIS_W-1:0] in_accel_y,
  input  logic signed [AXIS_W-1:0] in_accel_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_step_found,
  output logic [MAG_W-1:0]         out_magnitude,
  output logic [MODE_W-1:0]        out_gait_mode,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata
);

  pps_cmd_t cmd;
  pps_sts_t sts;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pps_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_accel_x     (in_accel_x),
    .in_accel_y     (in_accel_y),
    .in_accel_z     (in_accel_z),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_step_found (out_step_found),
    .out_magnitude  (out_magnitude),
    .out_gait_mode  (out_gait_mode)
  );

endmodule

@@ rtl/core/pps_ctrl.sv @@
// ----------------------------------------------------------------------------
// pps_ctrl
// Sequencer: squares, root iterations, history update, history scan and
// result hand-off.
// ----------------------------------------------------------------------------
module pps_ctrl
  import pps_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pps_sts_t sts,
  output pps_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_ROOT,
    S_UPD,
    S_SCAN,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.cnt       = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SQ;
          cnt_nxt   = '0;
        end
      end
      S_SQ: begin
        // product of axis k lands while axis k-1 is summed in
        cmd.sq_en  = (cnt_r < CNT_W'(SQ_STEPS - 1));
        cmd.acc_en = (cnt_r != '0);
        if (cnt_r == CNT_W'(SQ_STEPS - 1)) begin
          state_nxt = S_ROOT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = S_UPD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_SCAN;
        cnt_nxt   = '0;
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

@@ rtl/core/pps_dp.sv @@
// ----------------------------------------------------------------------------
// pps_dp
// Datapath: shared squarer, bit-serial square root, magnitude history,
// gait selection, peak scan and step decision, output register.
// ----------------------------------------------------------------------------
module pps_dp
  import pps_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  pps_cmd_t               cmd,
  output pps_sts_t               sts,
  input  logic signed [AXIS_W-1:0] in_accel_x,
  input  logic signed [AXIS_W-1:0] in_accel_y,
  input  logic signed [AXIS_W-1:0] in_accel_z,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_step_found,
  output logic [MAG_W-1:0]       out_magnitude,
  output logic [MODE_W-1:0]      out_gait_mode
);

  // configuration
  logic [MAG_W-1:0]     fast_thr_r, slow_thr_r;
  logic [VIB_W-1:0]     vib_slow_r, vib_normal_r, vib_fast_r;
  logic [SPANCFG_W-1:0] span_slow_r, span_normal_r, span_fast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_thr_r    <= 16'd5325;
      slow_thr_r    <= 16'd4506;
      vib_slow_r    <= 14'd205;
      vib_normal_r  <= 14'd410;
      vib_fast_r    <= 14'd614;
      span_slow_r   <= 10'd524;
      span_normal_r <= 10'd392;
      span_fast_r   <= 10'd262;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FAST_THR:    fast_thr_r    <= cfg_wdata;
        REG_SLOW_THR:    slow_thr_r    <= cfg_wdata;
        REG_VIB_SLOW:    vib_slow_r    <= cfg_wdata[VIB_W-1:0];
        REG_VIB_NORMAL:  vib_normal_r  <= cfg_wdata[VIB_W-1:0];
        REG_VIB_FAST:    vib_fast_r    <= cfg_wdata[VIB_W-1:0];
        REG_SPAN_SLOW:   span_slow_r   <= cfg_wdata[SPANCFG_W-1:0];
        REG_SPAN_NORMAL: span_normal_r <= cfg_wdata[SPANCFG_W-1:0];
        REG_SPAN_FAST:   span_fast_r   <= cfg_wdata[SPANCFG_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [SPAN_W-1:0] clamp_span(input logic [FIELD_W-1:0] n);
    logic [SPAN_W-1:0] res;
    if (n == '0) begin
      res = SPAN_W'(1);
    end else if (32'(n) > SPAN_LIM) begin
      res = SPAN_W'(SPAN_LIM);
    end else begin
      res = SPAN_W'(n);
    end
    return res;
  endfunction

  // sample capture and sum of squares
  logic signed [AXIS_W-1:0] ax_r, ay_r, az_r;
  logic signed [AXIS_W-1:0] axis_sel;
  logic signed [SQ_W-1:0]   sq_full;
  logic [SQ_W-1:0]          prod_r;

  always_comb begin
    case (cmd.cnt[1:0])
      2'd1:    axis_sel = ay_r;
      2'd2:    axis_sel = az_r;
      default: axis_sel = ax_r;
    endcase
  end

  assign sq_full = axis_sel * axis_sel;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_r <= in_accel_x;
      ay_r <= in_accel_y;
      az_r <= in_accel_z;
    end
    if (cmd.sq_en) begin
      prod_r <= unsigned'(sq_full);
    end
  end

  // square root, one result bit per cycle; rem_r doubles as the accumulator
  logic [SQ_W-1:0] rem_r, root_r, bit_r;
  logic [SQ_W:0]   trial;

  assign trial = {1'b0, root_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= '0;
      root_r <= '0;
      bit_r  <= SQ_W'(1) << (SQ_W - 2);
    end else if (cmd.acc_en) begin
      rem_r <= rem_r + prod_r;
    end else if (cmd.root_step) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_r  <= rem_r - trial[SQ_W-1:0];
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // history, gait and scan limits
  logic [MAG_W-1:0]     hist_r [HIST_DEPTH];
  logic [MAG_W-1:0]     mag_nxt, mag_r;
  logic [MODE_W-1:0]    mode_nxt, mode_r;
  logic [SPANCFG_W-1:0] span_sel;
  logic [VIB_W-1:0]     vib_sel, vib_r;
  logic [SPAN_W-1:0]    range_nxt, window_nxt, range_r, window_r, lim_r;

  assign mag_nxt = root_r[MAG_W-1:0];

  always_comb begin
    if (mag_nxt > fast_thr_r) begin
      mode_nxt = MODE_FAST;
      span_sel = span_fast_r;
      vib_sel  = vib_fast_r;
    end else if (mag_nxt < slow_thr_r) begin
      mode_nxt = MODE_SLOW;
      span_sel = span_slow_r;
      vib_sel  = vib_slow_r;
    end else begin
      mode_nxt = MODE_NORMAL;
      span_sel = span_normal_r;
      vib_sel  = vib_normal_r;
    end
  end

  assign range_nxt  = clamp_span(span_sel[FIELD_W-1:0]);
  assign window_nxt = clamp_span(span_sel[2*FIELD_W-1:FIELD_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (cmd.upd) begin
      hist_r[0] <= mag_nxt;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // peak scan over the history, one entry per cycle
  logic [IDX_W-1:0] idx;
  logic [MAG_W-1:0] hval, wmax_r, wmin_r;
  logic             lmax_r;

  assign idx  = cmd.cnt[IDX_W-1:0];
  assign hval = hist_r[idx];

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      mag_r    <= mag_nxt;
      mode_r   <= mode_nxt;
      vib_r    <= vib_sel;
      range_r  <= range_nxt;
      window_r <= window_nxt;
      lim_r    <= (range_nxt > window_nxt) ? range_nxt : window_nxt;
      lmax_r   <= 1'b1;
      wmax_r   <= mag_nxt;
      wmin_r   <= mag_nxt;
    end else if (cmd.scan_en) begin
      if (idx != '0 && 32'(idx) < 32'(range_r) && mag_r <= hval) begin
        lmax_r <= 1'b0;
      end
      if (32'(idx) < 32'(window_r)) begin
        if (hval > wmax_r) begin
          wmax_r <= hval;
        end
        if (hval < wmin_r) begin
          wmin_r <= hval;
        end
      end
    end
  end

  assign sts.scan_last = (32'(idx) == 32'(lim_r) - 1);

  // step decision
  logic [GAP_W-1:0]        gap_r;
  logic signed [MAG_W+1:0] prom;
  logic                    ok_gap, ok_prom, ok_vib, step;

  assign prom    = signed'({1'b0, mag_r, 1'b0}) - signed'({2'b0, wmax_r})
                 - signed'({2'b0, wmin_r});
  assign ok_prom = prom > signed'((MAG_W + 2)'(PROM_MIN));
  assign ok_gap  = 32'(gap_r) > 32'(range_r);
  // m - 1g >= vib, moved to the unsigned side
  assign ok_vib  = {1'b0, mag_r} >= ({3'b0, vib_r} + (MAG_W + 1)'(ONE_G));
  assign step    = lmax_r && ok_gap && ok_prom && ok_vib;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= '0;
    end else if (cmd.fin && lmax_r) begin
      if (step) begin
        gap_r <= '0;
      end else if (gap_r != '1) begin
        gap_r <= gap_r + 1'b1;
      end
    end
  end

  // output register
  logic              out_valid_r;
  logic              step_r;
  logic [MAG_W-1:0]  out_mag_r;
  logic [MODE_W-1:0] out_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      step_r     <= step;
      out_mag_r  <= mag_r;
      out_mode_r <= mode_r;
    end
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_step_found = step_r;
  assign out_magnitude  = out_mag_r;
  assign out_gait_mode  = out_mode_r;

endmodule
